[rtl/bfsp_pkg.sv]
// ============================================================================
// bfsp_pkg - shared types and constants of the shortest-path unit
// Field widths, register indexes, command codes, controller states and the
// command/status bundles between controller and datapath.
// ============================================================================
package bfsp_pkg;

    localparam int NODE_W     = 6;   // node number field
    localparam int NCNT_W     = 7;   // node count, holds 64
    localparam int DIST_W     = 40;  // signed distance
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_NODE = 1'b1;

    // input command codes
    localparam logic CMD_EDGE = 1'b0;
    localparam logic CMD_RUN  = 1'b1;

    localparam logic [NCNT_W-1:0] NODE_COUNT_RST = 7'd1;

    localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
    localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_NODE,
        S_EVAL,
        S_NEG,
        S_OUT_RD,
        S_OUT_LD
    } t_ctrl_state;

    typedef struct packed {
        logic              in_ready;
        logic              store_edge;
        logic              run_init;
        logic              fetch_first;
        logic              fetch_next;
        logic              node_rd;
        logic              relax_wr;
        logic [NODE_W-1:0] out_idx;
        logic              out_load_node;
        logic              out_load_neg;
        logic              out_last;
        logic              clr_edges;
    } t_dp_cmd;

    typedef struct packed {
        logic              in_valid;
        logic              in_cmd;
        logic              edge_empty;
        logic              edge_last;
        logic              relax_hit;
        logic              out_free;
        logic [NCNT_W-1:0] node_cnt;
    } t_dp_status;

endpackage

[rtl/bfsp_if.sv]
// ============================================================================
// bfsp_if - valid/ready channels of the shortest-path unit
// bfsp_cmd_if carries edge and run commands, bfsp_res_if carries results.
// ============================================================================
interface bfsp_cmd_if import bfsp_pkg::*; #(
    parameter int WEIGHT_BITS = 32
);
    logic                   valid;
    logic                   ready;
    logic                   cmd;
    logic [NODE_W-1:0]      from_node;
    logic [NODE_W-1:0]      to_node;
    logic [WEIGHT_BITS-1:0] weight;

    modport source (output valid, cmd, from_node, to_node, weight, input ready);
    modport sink   (input valid, cmd, from_node, to_node, weight, output ready);
endinterface

interface bfsp_res_if import bfsp_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [NODE_W-1:0]        node_index;
    logic                     reachable;
    logic signed [DIST_W-1:0] distance;
    logic                     has_parent;
    logic [NODE_W-1:0]        parent_node;
    logic                     negative_cycle;
    logic                     last;

    modport source (output valid, node_index, reachable, distance, has_parent,
                    parent_node, negative_cycle, last, input ready);
    modport sink   (input valid, node_index, reachable, distance, has_parent,
                    parent_node, negative_cycle, last, output ready);
endinterface

[rtl/bfsp_dp.sv]
// ============================================================================
// bfsp_dp - datapath of the shortest-path unit
// Config registers, edge store, node distance/parent memories, reached and
// parent-valid flags, saturating relax unit and the result register.
// ============================================================================
module bfsp_dp import bfsp_pkg::*; #(
    parameter int MAX_NODES   = 64,
    parameter int MAX_EDGES   = 1024,
    parameter int WEIGHT_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    bfsp_cmd_if.sink              i_edge,
    bfsp_res_if.source            o_res,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status
);

    localparam int NW    = $clog2(MAX_NODES);
    localparam int AW    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW    = $clog2(MAX_EDGES + 1);
    localparam int EW    = 2 * NODE_W + WEIGHT_BITS;
    localparam int SUM_W = ((WEIGHT_BITS > DIST_W) ? WEIGHT_BITS : DIST_W) + 1;
    localparam logic signed [SUM_W-1:0] SAT_HI = $signed({{(SUM_W-DIST_W){1'b0}}, DIST_MAX});
    localparam logic signed [SUM_W-1:0] SAT_LO = $signed({{(SUM_W-DIST_W){1'b1}}, DIST_MIN});

    // ---- configuration
    logic [NCNT_W-1:0] r_node_count;
    logic [NODE_W-1:0] r_source;
    logic [NCNT_W-1:0] act_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RST;
            r_source     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_NODE_COUNT:  r_node_count <= i_cfg_data[NCNT_W-1:0];
                CFG_SOURCE_NODE: r_source     <= i_cfg_data[NODE_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb begin
        if (r_node_count == '0) begin
            act_cnt = NCNT_W'(1);
        end else if (r_node_count > NCNT_W'(MAX_NODES)) begin
            act_cnt = NCNT_W'(MAX_NODES);
        end else begin
            act_cnt = r_node_count;
        end
    end

    // ---- edge store
    logic [EW-1:0] edge_mem [MAX_EDGES];
    logic [EW-1:0] r_edge;
    logic [CW-1:0] r_edge_cnt;
    logic [AW-1:0] r_k;
    logic [AW-1:0] fetch_addr;
    logic          store_ok;
    logic          fetch;

    assign store_ok   = i_cmd.store_edge && (r_edge_cnt < CW'(MAX_EDGES));
    assign fetch      = i_cmd.fetch_first || i_cmd.fetch_next;
    assign fetch_addr = i_cmd.fetch_first ? '0 : r_k + AW'(1);

    always_ff @(posedge i_clk) begin
        if (store_ok) begin
            edge_mem[r_edge_cnt[AW-1:0]] <= {i_edge.from_node, i_edge.to_node, i_edge.weight};
        end
        if (fetch) begin
            r_edge <= edge_mem[fetch_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_cnt <= '0;
            r_k        <= '0;
        end else begin
            if (i_cmd.clr_edges) begin
                r_edge_cnt <= '0;
            end else if (store_ok) begin
                r_edge_cnt <= r_edge_cnt + CW'(1);
            end
            if (fetch) begin
                r_k <= fetch_addr;
            end
        end
    end

    logic [NODE_W-1:0]             e_from;
    logic [NODE_W-1:0]             e_to;
    logic signed [WEIGHT_BITS-1:0] e_w;

    assign e_from = r_edge[EW-1 -: NODE_W];
    assign e_to   = r_edge[WEIGHT_BITS +: NODE_W];
    assign e_w    = $signed(r_edge[WEIGHT_BITS-1:0]);

    // ---- node state
    logic [DIST_W-1:0]        dist_mem [MAX_NODES];
    logic [NW-1:0]            par_mem  [MAX_NODES];
    logic [MAX_NODES-1:0]     r_reached;
    logic [MAX_NODES-1:0]     r_pvalid;
    logic signed [DIST_W-1:0] r_du;
    logic signed [DIST_W-1:0] r_dv;
    logic [NW-1:0]            r_par;
    logic                     r_ok;
    logic                     r_rv;

    logic [NW-1:0]            rd_a;
    logic [NW-1:0]            oi;
    logic [NW-1:0]            src_i;
    logic [NW-1:0]            u_i;
    logic [NW-1:0]            v_i;
    logic                     init_src;
    logic                     relax;
    logic                     dist_we;
    logic [NW-1:0]            dist_wa;
    logic [DIST_W-1:0]        dist_wd;

    assign oi       = i_cmd.out_idx[NW-1:0];
    assign src_i    = r_source[NW-1:0];
    assign u_i      = e_from[NW-1:0];
    assign v_i      = e_to[NW-1:0];
    assign rd_a     = i_cmd.node_rd ? u_i : oi;
    assign init_src = i_cmd.run_init && ({1'b0, r_source} < act_cnt);

    // relax unit: saturating d(u)+w, then compare against d(v)
    logic signed [SUM_W-1:0]  sum;
    logic signed [DIST_W-1:0] cand;
    logic                     hit;

    always_comb begin
        sum = $signed({{(SUM_W-DIST_W){r_du[DIST_W-1]}}, r_du})
            + $signed({{(SUM_W-WEIGHT_BITS){e_w[WEIGHT_BITS-1]}}, e_w});
        if (sum > SAT_HI) begin
            cand = DIST_MAX;
        end else if (sum < SAT_LO) begin
            cand = DIST_MIN;
        end else begin
            cand = sum[DIST_W-1:0];
        end
        hit = r_ok && (!r_rv || (cand < r_dv));
    end

    assign relax   = i_cmd.relax_wr && hit;
    assign dist_we = relax || init_src;
    assign dist_wa = relax ? v_i : src_i;
    assign dist_wd = relax ? cand : '0;

    always_ff @(posedge i_clk) begin
        r_du  <= dist_mem[rd_a];
        r_dv  <= dist_mem[v_i];
        r_par <= par_mem[oi];
        if (dist_we) begin
            dist_mem[dist_wa] <= dist_wd;
        end
        if (relax) begin
            par_mem[v_i] <= u_i;
        end
        if (i_cmd.node_rd) begin
            r_ok <= ({1'b0, e_from} < act_cnt) && ({1'b0, e_to} < act_cnt)
                    && r_reached[u_i];
            r_rv <= r_reached[v_i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reached <= '0;
            r_pvalid  <= '0;
        end else if (i_cmd.run_init) begin
            r_reached <= '0;
            r_pvalid  <= '0;
            if (init_src) begin
                r_reached[src_i] <= 1'b1;
            end
        end else if (relax) begin
            r_reached[v_i] <= 1'b1;
            r_pvalid[v_i]  <= 1'b1;
        end
    end

    // ---- result register
    logic                     r_out_valid;
    logic [NODE_W-1:0]        r_out_idx;
    logic                     r_out_reach;
    logic signed [DIST_W-1:0] r_out_dist;
    logic                     r_out_hasp;
    logic [NODE_W-1:0]        r_out_par;
    logic                     r_out_neg;
    logic                     r_out_last;
    logic                     out_free;

    assign out_free = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load_node || i_cmd.out_load_neg) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load_node) begin
            r_out_idx   <= i_cmd.out_idx;
            r_out_reach <= r_reached[oi];
            r_out_dist  <= r_reached[oi] ? r_du : '0;
            r_out_hasp  <= r_pvalid[oi];
            r_out_par   <= r_pvalid[oi] ? NODE_W'(r_par) : '0;
            r_out_neg   <= 1'b0;
            r_out_last  <= i_cmd.out_last;
        end else if (i_cmd.out_load_neg) begin
            r_out_idx   <= '0;
            r_out_reach <= 1'b0;
            r_out_dist  <= '0;
            r_out_hasp  <= 1'b0;
            r_out_par   <= '0;
            r_out_neg   <= 1'b1;
            r_out_last  <= 1'b1;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.node_index     = r_out_idx;
    assign o_res.reachable      = r_out_reach;
    assign o_res.distance       = r_out_dist;
    assign o_res.has_parent     = r_out_hasp;
    assign o_res.parent_node    = r_out_par;
    assign o_res.negative_cycle = r_out_neg;
    assign o_res.last           = r_out_last;

    assign i_edge.ready = i_cmd.in_ready;

    assign o_status.in_valid   = i_edge.valid;
    assign o_status.in_cmd     = i_edge.cmd;
    assign o_status.edge_empty = (r_edge_cnt == '0);
    assign o_status.edge_last  = ((CW'(r_k) + CW'(1)) == r_edge_cnt);
    assign o_status.relax_hit  = hit;
    assign o_status.out_free   = out_free;
    assign o_status.node_cnt   = act_cnt;

`ifndef ASSERT_OFF
    a_edge_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_edge_cnt <= CW'(MAX_EDGES))
        else $error("edge count past store depth");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_load_node || i_cmd.out_load_neg) |-> out_free)
        else $error("result register overwritten while pending");

    a_init_clears_parents: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.run_init |=> (r_pvalid == '0))
        else $error("parent flags not cleared at run start");
`endif

endmodule

[rtl/bfsp_ctrl.sv]
// ============================================================================
// bfsp_ctrl - run sequencer of the shortest-path unit
// Walks passes and stored edges, then steps the result emission.
// ============================================================================
module bfsp_ctrl import bfsp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_ctrl_state       r_state, n_state;
    logic [NCNT_W-1:0] r_pass, n_pass;
    logic [NODE_W-1:0] r_idx, n_idx;
    logic              chk_pass;
    logic              idx_last;

    // last pass over the edges is the negative-cycle check
    assign chk_pass = (r_pass + NCNT_W'(1)) == i_status.node_cnt;
    assign idx_last = ({1'b0, r_idx} + NCNT_W'(1)) == i_status.node_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pass  <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_pass  <= n_pass;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state = r_state;
        n_pass  = r_pass;
        n_idx   = r_idx;
        case (r_state)
            S_IDLE: begin
                if (i_status.in_valid && (i_status.in_cmd == CMD_RUN)) begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                n_pass  = '0;
                n_idx   = '0;
                n_state = i_status.edge_empty ? S_OUT_RD : S_NODE;
            end
            S_NODE: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (chk_pass && i_status.relax_hit) begin
                    n_state = S_NEG;
                end else if (i_status.edge_last) begin
                    if (chk_pass) begin
                        n_idx   = '0;
                        n_state = S_OUT_RD;
                    end else begin
                        n_pass  = r_pass + NCNT_W'(1);
                        n_state = S_NODE;
                    end
                end else begin
                    n_state = S_NODE;
                end
            end
            S_NEG: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_OUT_RD: begin
                n_state = S_OUT_LD;
            end
            S_OUT_LD: begin
                if (i_status.out_free) begin
                    if (idx_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + NODE_W'(1);
                        n_state = S_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.out_idx = r_idx;
        case (r_state)
            S_IDLE: begin
                o_cmd.in_ready   = 1'b1;
                o_cmd.store_edge = i_status.in_valid && (i_status.in_cmd == CMD_EDGE);
            end
            S_INIT: begin
                o_cmd.run_init    = 1'b1;
                o_cmd.fetch_first = !i_status.edge_empty;
            end
            S_NODE: begin
                o_cmd.node_rd = 1'b1;
            end
            S_EVAL: begin
                o_cmd.relax_wr = !chk_pass;
                if (chk_pass && i_status.relax_hit) begin
                    o_cmd.clr_edges = 1'b1;
                end else if (i_status.edge_last) begin
                    o_cmd.clr_edges   = chk_pass;
                    o_cmd.fetch_first = !chk_pass;
                end else begin
                    o_cmd.fetch_next = 1'b1;
                end
            end
            S_NEG: begin
                o_cmd.out_load_neg = i_status.out_free;
            end
            S_OUT_RD: begin
                o_cmd.out_load_node = 1'b0;
            end
            S_OUT_LD: begin
                o_cmd.out_load_node = i_status.out_free;
                o_cmd.out_last      = idx_last;
            end
            default: begin
                o_cmd.in_ready = 1'b0;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_pass_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> (r_pass < i_status.node_cnt))
        else $error("pass counter past node count");

    a_one_edge_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.fetch_first, o_cmd.fetch_next, o_cmd.store_edge}))
        else $error("conflicting edge store accesses");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT_LD) |-> ({1'b0, r_idx} < i_status.node_cnt))
        else $error("result index past node count");
`endif

endmodule

[rtl/bellman_ford_shortest_paths_unit.sv]
// ============================================================================
// bellman_ford_shortest_paths_unit - single-source shortest paths engine
// Stores a directed weighted edge list and runs Bellman-Ford over it.
// ============================================================================
// Usage:
//  i_edge (valid/ready): cmd=0 stores one edge (one transaction per cycle
//    while idle; edges beyond MAX_EDGES are dropped). cmd=1 starts a run
//    from the configured source over nodes 0..node_count-1.
//  o_res (valid/ready): one transaction per node in index order, last set on
//    the final one, or a single transaction with negative_cycle set.
//  Config port (i_cfg_we/idx/data): node_count and source_node, to be
//    written only while the unit is idle; the block does not enforce it.
//  Run: an init step, then node_count passes (node_count-1 relax passes,
//    one check pass) over the stored edges, one edge at a time: read
//    (S_NODE), then evaluate (S_EVAL) against the distance memory, which
//    relax passes write on improvement. Then each result is read and loaded.
//  A run clears the edge count. i_edge.ready is low during a run.
//  A stalled receiver holds the result register; the sequencer waits.
//  The final result can still sit in the register while new edges load.
//  Reset (synchronous, active low): empty edge store, node_count=1,
//  source_node=0, no pending result. No clearing pass is needed.
// ============================================================================
module bellman_ford_shortest_paths_unit import bfsp_pkg::*; #(
    parameter int MAX_NODES   = 64,
    parameter int MAX_EDGES   = 1024,
    parameter int WEIGHT_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    bfsp_cmd_if.sink              i_edge,
    bfsp_res_if.source            o_res
);

    // command/status bundle between sequencer and datapath
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    bfsp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (dp_status),
        .o_cmd    (dp_cmd)
    );

    bfsp_dp #(
        .MAX_NODES   (MAX_NODES),
        .MAX_EDGES   (MAX_EDGES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_edge     (i_edge),
        .o_res      (o_res),
        .i_cmd      (dp_cmd),
        .o_status   (dp_status)
    );

endmodule

[sim/tb.sv]
// ============================================================================
// tb - testbench of the Bellman-Ford shortest-path unit
// Loads edge lists, starts runs over several node counts and sources, and
// compares every result transaction with a built-in shortest-path predictor.
// Both channels idle at random; the receiver also holds off for a long
// stretch so the unit backs up and stalls its edge input.
// ============================================================================
module tb import bfsp_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_NODES      = 64;
    localparam int MAX_EDGES      = 1024;
    localparam int WEIGHT_BITS    = 32;
    localparam int SETTLE_CYCLES  = 4;      // settle time after the results drain
    localparam int HOLD_CYCLES    = 300;    // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 200000; // watchdog limit for a stretch with no transaction
    localparam int RANDOM_ITEMS   = 100;

    // one result transaction as the predictor sees it
    typedef struct packed {
        logic [NODE_W-1:0] node_index;
        logic              reachable;
        logic [DIST_W-1:0] distance;
        logic              has_parent;
        logic [NODE_W-1:0] parent_node;
        logic              negative_cycle;
        logic              last;
    } t_path_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    bfsp_cmd_if #(.WEIGHT_BITS(WEIGHT_BITS)) edge_if ();
    bfsp_res_if                              res_if ();

    bellman_ford_shortest_paths_unit #(
        .MAX_NODES   (MAX_NODES),
        .MAX_EDGES   (MAX_EDGES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_edge     (edge_if),
        .o_res      (res_if)
    );

    // ------------------------------------------------------------------------
    // Predictor state: register shadows and the stored edge list
    // ------------------------------------------------------------------------
    logic [NCNT_W-1:0] cfg_node_count;
    logic [NODE_W-1:0] cfg_source;
    logic [NODE_W-1:0] edge_from [MAX_EDGES];
    logic [NODE_W-1:0] edge_to   [MAX_EDGES];
    longint            edge_wt   [MAX_EDGES];
    int                edge_cnt;

    t_path_result      pending_paths [$];   // expected results, oldest first
    int                errors;

    // traffic shaping, changed by the tests
    bit                tx_idle_on;
    bit                rx_idle_on;
    int                rx_hold_len;

    // ------------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // node_count as the unit uses it: 0 acts as 1, above 64 acts as 64
    function automatic int active_nodes();
        if (cfg_node_count == 0) return 1;
        if (cfg_node_count > MAX_NODES) return MAX_NODES;
        return int'(cfg_node_count);
    endfunction

    // d(u) + w clipped to the signed 40-bit range
    function automatic longint sat_dist(longint s);
        if (s > longint'(DIST_MAX)) return longint'(DIST_MAX);
        if (s < longint'(DIST_MIN)) return longint'(DIST_MIN);
        return s;
    endfunction

    // Run item: relax passes in arrival order with in-place updates, then a
    // check pass. Edges out of node range or leaving an unreached node are
    // skipped everywhere. Queues the results and clears the edge list.
    function automatic void compute_shortest_paths();
        int                n;
        int                u;
        int                v;
        longint            cand;
        bit                cycle;
        longint            node_dist [MAX_NODES];
        bit                reached   [MAX_NODES];
        bit                has_par   [MAX_NODES];
        logic [NODE_W-1:0] par       [MAX_NODES];
        t_path_result      r;

        n     = active_nodes();
        cycle = 1'b0;
        for (int i = 0; i < MAX_NODES; i++) begin
            node_dist[i] = 0;
            reached[i]   = 1'b0;
            has_par[i]   = 1'b0;
            par[i]       = '0;
        end
        if (cfg_source < n) reached[cfg_source] = 1'b1;

        for (int p = 0; p + 1 < n; p++) begin
            for (int k = 0; k < edge_cnt; k++) begin
                u = edge_from[k];
                v = edge_to[k];
                if (u >= n || v >= n || !reached[u]) continue;
                cand = sat_dist(node_dist[u] + edge_wt[k]);
                if (!reached[v] || cand < node_dist[v]) begin
                    reached[v]   = 1'b1;
                    node_dist[v] = cand;
                    has_par[v]   = 1'b1;
                    par[v]       = u[NODE_W-1:0];
                end
            end
        end

        for (int k = 0; k < edge_cnt && !cycle; k++) begin
            u = edge_from[k];
            v = edge_to[k];
            if (u >= n || v >= n || !reached[u]) continue;
            cand = sat_dist(node_dist[u] + edge_wt[k]);
            if (!reached[v] || cand < node_dist[v]) cycle = 1'b1;
        end

        edge_cnt = 0;

        if (cycle) begin
            r                = '0;
            r.negative_cycle = 1'b1;
            r.last           = 1'b1;
            pending_paths.push_back(r);
            return;
        end
        for (int i = 0; i < n; i++) begin
            r                = '0;
            r.node_index     = i[NODE_W-1:0];
            r.reachable      = reached[i];
            r.distance       = reached[i] ? node_dist[i][DIST_W-1:0] : '0;
            r.has_parent     = has_par[i];
            r.parent_node    = has_par[i] ? par[i] : '0;
            r.last           = (i + 1 == n);
            pending_paths.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Edge/run channel driver
    // ------------------------------------------------------------------------
    task automatic send_item(logic cmd, logic [NODE_W-1:0] src, logic [NODE_W-1:0] dst,
                             logic [WEIGHT_BITS-1:0] wt);
        int gap;

        gap = tx_idle_on ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            edge_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        edge_if.valid     <= 1'b1;
        edge_if.cmd       <= cmd;
        edge_if.from_node <= src;
        edge_if.to_node   <= dst;
        edge_if.weight    <= wt;
        @(posedge i_clk);
        while (edge_if.ready !== 1'b1) @(posedge i_clk);
        // transaction taken at this edge
        if (cmd == CMD_EDGE) begin
            if (edge_cnt < MAX_EDGES) begin   // full store drops the edge
                edge_from[edge_cnt] = src;
                edge_to[edge_cnt]   = dst;
                edge_wt[edge_cnt]   = longint'($signed(wt));
                edge_cnt++;
            end
        end else begin
            compute_shortest_paths();
        end
    endtask

    task automatic send_edge(int src, int dst, logic [WEIGHT_BITS-1:0] wt);
        send_item(CMD_EDGE, src[NODE_W-1:0], dst[NODE_W-1:0], wt);
    endtask

    task automatic send_run();
        // endpoint and weight fields are don't-care on a run; fill them anyway
        send_item(CMD_RUN, NODE_W'($urandom), NODE_W'($urandom), WEIGHT_BITS'($urandom));
    endtask

    // Stop offering, wait for every expected result, then let the unit settle
    // so trailing edge loads are done before any register write.
    task automatic drain_results();
        edge_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_paths.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx == CFG_NODE_COUNT) cfg_node_count = data;
        else                       cfg_source     = data[NODE_W-1:0];
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // mostly small positive weights, some small signed, some full range
    function automatic logic [WEIGHT_BITS-1:0] rand_weight();
        int r;

        r = $urandom_range(0, 9);
        if (r < 6) return WEIGHT_BITS'($urandom_range(0, 1000));
        if (r < 8) return WEIGHT_BITS'(int'($urandom_range(0, 200)) - 100);
        return WEIGHT_BITS'($urandom);
    endfunction

    // ------------------------------------------------------------------------
    // Result channel: random ready gaps, optional long hold, compare
    // ------------------------------------------------------------------------
    task automatic check_field(string name, logic [DIST_W-1:0] want, logic [DIST_W-1:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
        end
    endtask

    task automatic check_result(t_path_result got);
        t_path_result want;

        if (pending_paths.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: expected none, actual node %0d neg %0b",
                     $time, got.node_index, got.negative_cycle);
            return;
        end
        want = pending_paths.pop_front();
        check_field("node_index",     DIST_W'(want.node_index),     DIST_W'(got.node_index));
        check_field("reachable",      DIST_W'(want.reachable),      DIST_W'(got.reachable));
        check_field("distance",       want.distance,                got.distance);
        check_field("has_parent",     DIST_W'(want.has_parent),     DIST_W'(got.has_parent));
        check_field("parent_node",    DIST_W'(want.parent_node),    DIST_W'(got.parent_node));
        check_field("negative_cycle", DIST_W'(want.negative_cycle), DIST_W'(got.negative_cycle));
        check_field("last",           DIST_W'(want.last),           DIST_W'(got.last));
    endtask

    initial begin : result_sink
        int           gap;
        t_path_result got;

        res_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            // a requested hold-off is served here, counted in this process
            gap         = (rx_idle_on ? $urandom_range(0, 14) : 0) + rx_hold_len;
            rx_hold_len = 0;
            if (gap > 0) begin
                res_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            @(posedge i_clk);
            while (res_if.valid !== 1'b1) @(posedge i_clk);
            got.node_index     = res_if.node_index;
            got.reachable      = res_if.reachable;
            got.distance       = res_if.distance;
            got.has_parent     = res_if.has_parent;
            got.parent_node    = res_if.parent_node;
            got.negative_cycle = res_if.negative_cycle;
            got.last           = res_if.last;
            check_result(got);
        end
    end

    // Watchdog: cycles without a transaction on either channel
    initial begin : watchdog
        int quiet;

        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((edge_if.valid === 1'b1 && edge_if.ready === 1'b1) ||
                (res_if.valid === 1'b1 && res_if.ready === 1'b1)) quiet = 0;
            else quiet++;
        end
        $display("%0t: watchdog: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset values: one node, source 0. An empty run reports node 0 at 0;
    // a negative self-loop at the source is caught by the check pass alone.
    task automatic test_reset_defaults();
        send_run();
        send_edge(0, 0, -32'sd1);
        send_edge(1, 0, 32'sd4);            // out of range at one node
        send_run();
        drain_results();
    endtask

    // Register extremes, out-of-range endpoints and source, weight extremes.
    task automatic test_config_extremes();
        write_reg(CFG_NODE_COUNT, 7'd0);    // acts as one node
        send_run();
        drain_results();
        write_reg(CFG_NODE_COUNT, 7'd127);  // clipped to 64 nodes
        send_run();
        drain_results();

        write_reg(CFG_NODE_COUNT, 7'd64);
        write_reg(CFG_SOURCE_NODE, 7'd63);
        send_edge(63, 0, -32'sd7);
        send_edge(0, 62, 32'sd3);
        send_edge(0, 63, 32'h7fff_ffff);
        send_edge(5, 6, 32'sd1);            // leaves an unreached node
        send_run();
        drain_results();

        write_reg(CFG_NODE_COUNT, 7'd3);
        write_reg(CFG_SOURCE_NODE, 7'd0);
        send_edge(0, 1, 32'h7fff_ffff);
        send_edge(1, 2, 32'h8000_0000);
        send_edge(0, 2, 32'sd0);
        send_edge(0, 63, 32'sd1);           // endpoints outside node range
        send_edge(63, 1, -32'sd9);
        send_run();
        drain_results();

        write_reg(CFG_SOURCE_NODE, 7'd5);   // source beyond node count
        send_edge(0, 1, 32'sd2);
        send_run();
        drain_results();
    endtask

    // Reachable negative cycle, then one the source cannot reach.
    task automatic test_negative_cycle();
        write_reg(CFG_NODE_COUNT, 7'd4);
        write_reg(CFG_SOURCE_NODE, 7'd0);
        send_edge(0, 1, 32'sd1);
        send_edge(1, 2, -32'sd3);
        send_edge(2, 1, 32'sd1);
        send_run();
        send_edge(2, 3, -32'sd5);
        send_edge(3, 2, 32'sd1);
        send_edge(0, 1, 32'sd4);
        send_run();
        drain_results();
    endtask

    // Repeated most-negative self-loops drive the source distance into the
    // lower clip; once clipped the check pass sees no further improvement.
    task automatic test_distance_saturation();
        write_reg(CFG_NODE_COUNT, 7'd2);
        write_reg(CFG_SOURCE_NODE, 7'd0);
        tx_idle_on = 1'b0;
        repeat (300) send_edge(0, 0, 32'h8000_0000);
        send_edge(0, 1, -32'sd1);
        send_run();
        drain_results();
    endtask

    // Overfill the edge store, run, then run again to show the count cleared.
    task automatic test_store_full();
        write_reg(CFG_NODE_COUNT, 7'd4);
        write_reg(CFG_SOURCE_NODE, 7'd0);
        tx_idle_on = 1'b0;
        repeat (MAX_EDGES + 6) begin
            send_edge($urandom_range(0, 3), $urandom_range(0, 3),
                      WEIGHT_BITS'($urandom_range(0, 1000)));
        end
        tx_idle_on = 1'b1;
        send_run();
        send_run();
        drain_results();
    endtask

    // Receiver holds off while the sender keeps offering the next phase.
    task automatic test_backpressure();
        write_reg(CFG_NODE_COUNT, 7'd16);
        write_reg(CFG_SOURCE_NODE, 7'd0);
        tx_idle_on  = 1'b0;
        rx_hold_len = HOLD_CYCLES;
        repeat (20) send_edge($urandom_range(0, 15), $urandom_range(0, 15), rand_weight());
        send_run();
        repeat (10) send_edge($urandom_range(0, 15), $urandom_range(0, 15), rand_weight());
        send_run();
        tx_idle_on = 1'b1;
        send_edge(0, 15, 32'sd9);
        send_run();
        drain_results();
    endtask

    // Random phases: mostly in-range edge lists ending in a run, some noise
    // edges; new settings only after the unit has drained.
    task automatic test_random_graphs();
        int items;
        int n;
        int r;

        items = 0;
        while (items < RANDOM_ITEMS) begin
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 2) != 0) begin
                drain_results();
                r = $urandom_range(0, 9);
                if (r == 0)      write_reg(CFG_NODE_COUNT, 7'd0);
                else if (r == 1) write_reg(CFG_NODE_COUNT, 7'd64);
                else if (r == 2) write_reg(CFG_NODE_COUNT, 7'($urandom_range(65, 127)));
                else             write_reg(CFG_NODE_COUNT, 7'($urandom_range(1, 12)));
                n = active_nodes();
                if ($urandom_range(0, 6) != 0)
                    write_reg(CFG_SOURCE_NODE, 7'($urandom_range(0, n - 1)));
                else
                    write_reg(CFG_SOURCE_NODE, 7'($urandom_range(0, 63)));
            end
            n = active_nodes();
            repeat ($urandom_range(0, 12)) begin
                if ($urandom_range(0, 9) < 8)
                    send_edge($urandom_range(0, n - 1), $urandom_range(0, n - 1),
                              rand_weight());
                else
                    send_edge($urandom_range(0, 63), $urandom_range(0, 63), rand_weight());
                items++;
            end
            send_run();
            items++;
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        errors         = 0;
        edge_cnt       = 0;
        cfg_node_count = NODE_COUNT_RST;
        cfg_source     = '0;
        tx_idle_on     = 1'b1;
        rx_idle_on     = 1'b1;
        rx_hold_len    = 0;

        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= CFG_NODE_COUNT;
        i_cfg_data        <= '0;
        edge_if.valid     <= 1'b0;
        edge_if.cmd       <= CMD_EDGE;
        edge_if.from_node <= '0;
        edge_if.to_node   <= '0;
        edge_if.weight    <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_config_extremes();
        test_negative_cycle();
        test_distance_saturation();
        test_store_full();
        test_backpressure();
        test_random_graphs();

        // trailing window: any stray result is flagged by the sink
        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending_paths.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/bfsp_pkg.sv
rtl/bfsp_if.sv
rtl/bfsp_dp.sv
rtl/bfsp_ctrl.sv
rtl/bellman_ford_shortest_paths_unit.sv
sim/tb.sv
